[rtl/drd_pkg.sv]
// ----------------------------------------------------------------------------
// drd_pkg : shared constants for the detection row decoder
// Row layout, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package drd_pkg;

    // row layout
    localparam int unsigned BOX_FIELDS  = 4;
    localparam int unsigned MAX_CLASSES = 80;
    localparam int unsigned POS_W       = 11;
    localparam int unsigned CLASS_W     = 10;

    // field widths
    localparam int unsigned FEAT_W  = 32;
    localparam int unsigned CONF_W  = 16;
    localparam int unsigned SCALE_W = 24;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned EXT_W   = 13;
    localparam int unsigned OUT_W   = 80;

    // largest image size used for clamping
    localparam logic [DIM_W-1:0] IMG_MAX = 13'd4096;

    // configuration register indexes (byte address = 4 * index)
    localparam int unsigned      ADDR_W              = 5;
    localparam logic [2:0]       REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0]       REG_X_SCALE         = 3'd1;
    localparam logic [2:0]       REG_Y_SCALE         = 3'd2;
    localparam logic [2:0]       REG_IMAGE_WIDTH     = 3'd3;
    localparam logic [2:0]       REG_IMAGE_HEIGHT    = 3'd4;

    // reset values
    localparam logic [CONF_W-1:0]  RST_THRESHOLD = 16'd16384;
    localparam logic [SCALE_W-1:0] RST_SCALE     = 24'd65536;
    localparam logic [DIM_W-1:0]   RST_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT    = 13'd480;

endpackage

[rtl/detection_row_decode.sv]
// ----------------------------------------------------------------------------
// detection_row_decode : detector output row to corner box detection
// Accumulates one candidate row per run of features, picks the best class
// and emits a scaled, clamped box if non-empty and the score passes the threshold.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one signed Q15.16 feature per transfer in s_axis_tdata,
//   s_axis_tlast on the final feature of a row. Features 0..3 are centre x,
//   centre y, width and height; 4..83 are class scores, later ones ignored.
//   Master stream: at most one detection per row, all fields in m_axis_tdata.
//   APB port: five registers at byte addresses 0,4,8,12,16; write whenever
//   no row is in flight.
// Throughput: one feature per clock while s_axis_tready is high; a new row may
//   start in the cycle after the previous row's last feature.
// Path: the last feature passes the input register, row result, corner
//   offset add, scale multiply and clamp into the output register, which
//   drives m_axis_tvalid with the detection.
// Stall: the pipeline stages are elastic; non-last features keep streaming
//   into the row accumulator while a detection waits on m_axis_tready, and
//   s_axis_tready drops only once the finished rows fill the pipeline.
// Reset: synchronous, active low; clears the pipeline, the row accumulator
//   and loads the register defaults (threshold 0.25, unity scales, 640x480).
// ----------------------------------------------------------------------------
module detection_row_decode (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [drd_pkg::FEAT_W-1:0]       s_axis_tdata,   // [31:0] feature_value
    input  logic                             s_axis_tlast,   // last_feature
    // stream out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [9:0] class_index, [25:10] confidence, [37:26] box_left,
    // [49:38] box_top, [62:50] box_width, [75:63] box_height, [79:76] zero
    output logic [drd_pkg::OUT_W-1:0]        m_axis_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drd_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    typedef struct packed {
        logic                          ok;
        logic [drd_pkg::COORD_W-1:0]   pos;
        logic [drd_pkg::EXT_W-1:0]     ext;
    } t_axis;

    // corner and extent along one axis from the scaled products
    function automatic t_axis axis_clamp(input logic signed [58:0] pp,
                                         input logic signed [56:0] ep,
                                         input logic [drd_pkg::DIM_W-1:0] dim);
        logic [drd_pkg::DIM_W-1:0] lim;
        logic [drd_pkg::DIM_W-1:0] lim_m1;
        logic [drd_pkg::DIM_W-1:0] pos;
        logic [drd_pkg::DIM_W-1:0] room;
        logic [24:0]               pq;
        logic [24:0]               eq;
        logic [drd_pkg::EXT_W-1:0] ext;
        t_axis                     res;
        lim    = (dim > drd_pkg::IMG_MAX) ? drd_pkg::IMG_MAX : dim;
        lim_m1 = lim - 13'd1;
        pq     = pp[57:33];
        eq     = ep[56:32];
        // a negative corner truncates to at most zero and clamps to zero
        if (pp[58])
            pos = '0;
        else if (pq > {12'd0, lim_m1})
            pos = lim_m1;
        else
            pos = pq[12:0];
        room = lim - pos;
        ext  = (eq > {12'd0, room}) ? room : eq[12:0];
        res.ok  = (lim != '0) && !ep[56] && (ext != '0);
        res.pos = pos[11:0];
        res.ext = ext;
        return res;
    endfunction

    // configuration registers
    logic [drd_pkg::CONF_W-1:0]  r_thr;
    logic [drd_pkg::SCALE_W-1:0] r_xs;
    logic [drd_pkg::SCALE_W-1:0] r_ys;
    logic [drd_pkg::DIM_W-1:0]   r_iw;
    logic [drd_pkg::DIM_W-1:0]   r_ih;
    logic                        cfg_wr;

    // stage 0: input register
    logic                             r_in_v;
    logic signed [drd_pkg::FEAT_W-1:0] r_in_data;
    logic                             r_in_last;

    // row accumulator
    logic [drd_pkg::POS_W-1:0]         r_pos;
    logic signed [drd_pkg::FEAT_W-1:0] r_cx, r_cy, r_rw, r_rh, r_best;
    logic [drd_pkg::CLASS_W-1:0]       r_cls;

    logic [drd_pkg::POS_W-1:0]         n_pos;
    logic signed [drd_pkg::FEAT_W-1:0] n_cx, n_cy, n_rw, n_rh, n_best;
    logic [drd_pkg::CLASS_W-1:0]       n_cls;
    logic [drd_pkg::POS_W-1:0]         cls_pos;
    logic                              is_score;
    logic                              pass;
    logic [drd_pkg::CONF_W-1:0]        n_conf;

    // stage 1: finished row
    logic                              r_j_v;
    logic signed [drd_pkg::FEAT_W-1:0] r_j_cx, r_j_cy, r_j_w, r_j_h;
    logic [drd_pkg::CLASS_W-1:0]       r_j_cls;
    logic [drd_pkg::CONF_W-1:0]        r_j_conf;
    logic signed [33:0]                n_dx, n_dy;

    // stage 2: doubled corner offset
    logic                              r_t_v;
    logic signed [33:0]                r_t_dx, r_t_dy;
    logic signed [drd_pkg::FEAT_W-1:0] r_t_w, r_t_h;
    logic [drd_pkg::CLASS_W-1:0]       r_t_cls;
    logic [drd_pkg::CONF_W-1:0]        r_t_conf;
    logic signed [58:0]                n_px, n_py;
    logic signed [56:0]                n_ex, n_ey;

    // stage 3: scaled products
    logic                              r_p_v;
    logic signed [58:0]                r_p_px, r_p_py;
    logic signed [56:0]                r_p_ex, r_p_ey;
    logic [drd_pkg::CLASS_W-1:0]       r_p_cls;
    logic [drd_pkg::CONF_W-1:0]        r_p_conf;
    t_axis                             ax_x, ax_y;

    // output register
    logic                              r_o_v;
    logic [drd_pkg::CLASS_W-1:0]       r_o_cls;
    logic [drd_pkg::CONF_W-1:0]        r_o_conf;
    logic [drd_pkg::COORD_W-1:0]       r_o_left, r_o_top;
    logic [drd_pkg::EXT_W-1:0]         r_o_w, r_o_h;

    // elastic handshake
    logic rdy_o, rdy_p, rdy_t, rdy_j, s0_adv;

    assign rdy_o  = !r_o_v || m_axis_tready;
    assign rdy_p  = !r_p_v || rdy_o;
    assign rdy_t  = !r_t_v || rdy_p;
    assign rdy_j  = !r_j_v || rdy_t;
    // only the last feature of a row needs room further down
    assign s0_adv = r_in_v && (!r_in_last || rdy_j);
    assign s_axis_tready = !r_in_v || s0_adv;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= drd_pkg::RST_THRESHOLD;
            r_xs  <= drd_pkg::RST_SCALE;
            r_ys  <= drd_pkg::RST_SCALE;
            r_iw  <= drd_pkg::RST_WIDTH;
            r_ih  <= drd_pkg::RST_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                drd_pkg::REG_SCORE_THRESHOLD: r_thr <= pwdata[15:0];
                drd_pkg::REG_X_SCALE:         r_xs  <= pwdata[23:0];
                drd_pkg::REG_Y_SCALE:         r_ys  <= pwdata[23:0];
                drd_pkg::REG_IMAGE_WIDTH:     r_iw  <= pwdata[12:0];
                drd_pkg::REG_IMAGE_HEIGHT:    r_ih  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            drd_pkg::REG_SCORE_THRESHOLD: prdata = {16'd0, r_thr};
            drd_pkg::REG_X_SCALE:         prdata = {8'd0, r_xs};
            drd_pkg::REG_Y_SCALE:         prdata = {8'd0, r_ys};
            drd_pkg::REG_IMAGE_WIDTH:     prdata = {19'd0, r_iw};
            drd_pkg::REG_IMAGE_HEIGHT:    prdata = {19'd0, r_ih};
            default:                      prdata = '0;
        endcase
    end

    // --------------------------------------------------------- input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------- row accumulator
    assign cls_pos  = r_pos - drd_pkg::POS_W'(drd_pkg::BOX_FIELDS);
    assign is_score = (r_pos >= drd_pkg::POS_W'(drd_pkg::BOX_FIELDS)) &&
                      (r_pos < drd_pkg::POS_W'(drd_pkg::BOX_FIELDS + drd_pkg::MAX_CLASSES));

    always_comb begin
        n_cx   = (r_pos == 11'd0) ? r_in_data : r_cx;
        n_cy   = (r_pos == 11'd1) ? r_in_data : r_cy;
        n_rw   = (r_pos == 11'd2) ? r_in_data : r_rw;
        n_rh   = (r_pos == 11'd3) ? r_in_data : r_rh;
        n_best = r_best;
        n_cls  = r_cls;
        // first strictly largest score wins
        if (is_score && (r_in_data > r_best)) begin
            n_best = r_in_data;
            n_cls  = cls_pos[drd_pkg::CLASS_W-1:0];
        end
        n_pos  = (r_pos == '1) ? r_pos : r_pos + 11'd1;
        pass   = n_best > $signed({16'd0, r_thr});
        n_conf = (n_best > 32'sd65535) ? 16'hFFFF : n_best[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_rw   <= '0;
            r_rh   <= '0;
            r_best <= '0;
            r_cls  <= '0;
        end else if (s0_adv) begin
            if (r_in_last) begin
                r_pos  <= '0;
                r_cx   <= '0;
                r_cy   <= '0;
                r_rw   <= '0;
                r_rh   <= '0;
                r_best <= '0;
                r_cls  <= '0;
            end else begin
                r_pos  <= n_pos;
                r_cx   <= n_cx;
                r_cy   <= n_cy;
                r_rw   <= n_rw;
                r_rh   <= n_rh;
                r_best <= n_best;
                r_cls  <= n_cls;
            end
        end
    end

    // ------------------------------------------------------- stage 1: row out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else if (rdy_j) begin
            r_j_v <= s0_adv && r_in_last && pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_j) begin
            r_j_cx   <= n_cx;
            r_j_cy   <= n_cy;
            r_j_w    <= n_rw;
            r_j_h    <= n_rh;
            r_j_cls  <= n_cls;
            r_j_conf <= n_conf;
        end
    end

    // 2*centre - size, needs 34 bits
    assign n_dx = {r_j_cx[31], r_j_cx, 1'b0} - {{2{r_j_w[31]}}, r_j_w};
    assign n_dy = {r_j_cy[31], r_j_cy, 1'b0} - {{2{r_j_h[31]}}, r_j_h};

    // ------------------------------------------------------ stage 2: offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (rdy_t) begin
            r_t_v <= r_j_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_t) begin
            r_t_dx   <= n_dx;
            r_t_dy   <= n_dy;
            r_t_w    <= r_j_w;
            r_t_h    <= r_j_h;
            r_t_cls  <= r_j_cls;
            r_t_conf <= r_j_conf;
        end
    end

    assign n_px = r_t_dx * $signed({1'b0, r_xs});
    assign n_py = r_t_dy * $signed({1'b0, r_ys});
    assign n_ex = r_t_w  * $signed({1'b0, r_xs});
    assign n_ey = r_t_h  * $signed({1'b0, r_ys});

    // ----------------------------------------------------- stage 3: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (rdy_p) begin
            r_p_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_p) begin
            r_p_px   <= n_px;
            r_p_py   <= n_py;
            r_p_ex   <= n_ex;
            r_p_ey   <= n_ey;
            r_p_cls  <= r_t_cls;
            r_p_conf <= r_t_conf;
        end
    end

    assign ax_x = axis_clamp(r_p_px, r_p_ex, r_iw);
    assign ax_y = axis_clamp(r_p_py, r_p_ey, r_ih);

    // ------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (rdy_o) begin
            r_o_v <= r_p_v && ax_x.ok && ax_y.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_cls  <= r_p_cls;
            r_o_conf <= r_p_conf;
            r_o_left <= ax_x.pos;
            r_o_top  <= ax_y.pos;
            r_o_w    <= ax_x.ext;
            r_o_h    <= ax_y.ext;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {4'd0, r_o_h, r_o_w, r_o_top, r_o_left, r_o_conf, r_o_cls};

    // ------------------------------------------------------------ assertions
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_adv && r_in_last) |=> (r_pos == '0 && r_best == '0 && r_cls == '0))
        else $error("row accumulator not cleared after last feature");

    a_box_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_o_w != '0 && r_o_h != '0))
        else $error("detection with empty box");

    a_conf_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_o_conf != '0))
        else $error("detection with zero confidence");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_v && r_in_last && r_j_v))
        else $error("input stalled without a finished row waiting");

endmodule

[tb/tb_detection_row_decode.sv]
// ----------------------------------------------------------------------------
// tb_detection_row_decode : self-checking bench for the detection row decoder
// Streams candidate rows through the slave port with random gaps. A built-in
// row decoder predicts each detection and the master side is checked field by
// field. Several register settings are tried, including the extremes, a
// degenerate image size and one that is oversized. The sink stalls at random
// and once holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_detection_row_decode;

    localparam int POS_LIMIT    = (1 << drd_pkg::POS_W) - 1;
    localparam int CONF_MAX     = (1 << drd_pkg::CONF_W) - 1;
    localparam int PAD_W        = drd_pkg::OUT_W - drd_pkg::CLASS_W - drd_pkg::CONF_W
                                  - 2 * drd_pkg::COORD_W - 2 * drd_pkg::EXT_W;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_ROW     = 300;
    localparam int STALL_ROWS   = 16;
    localparam int PHASES       = 9;

    typedef struct packed {
        logic [PAD_W-1:0]            pad;
        logic [drd_pkg::EXT_W-1:0]   box_height;
        logic [drd_pkg::EXT_W-1:0]   box_width;
        logic [drd_pkg::COORD_W-1:0] box_top;
        logic [drd_pkg::COORD_W-1:0] box_left;
        logic [drd_pkg::CONF_W-1:0]  confidence;
        logic [drd_pkg::CLASS_W-1:0] class_index;
    } t_detection;

    // how a directed entry is checked
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_DET} t_check_kind;

    typedef struct {
        logic [drd_pkg::FEAT_W-1:0] feat;
        logic                       last;
        t_check_kind                chk;
        t_detection                 det;
    } t_stim;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [drd_pkg::FEAT_W-1:0]   s_axis_tdata  = '0;  // [31:0] feature_value
    logic                         s_axis_tlast  = 1'b0; // last_feature
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [9:0] class_index, [25:10] confidence, [37:26] box_left,
    // [49:38] box_top, [62:50] box_width, [75:63] box_height, [79:76] zero
    logic [drd_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [drd_pkg::ADDR_W-1:0]   paddr         = '0;
    logic [31:0]                  pwdata        = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    detection_row_decode DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state and register shadow
    int         reg_shadow [0:drd_pkg::REG_IMAGE_HEIGHT];
    int         row_pos, ctr_x, ctr_y, box_w, box_h, top_score, top_class;
    t_detection pending_dets [$];
    t_stim      dir_tab [$];

    int errors = 0;
    int n_items = 0;
    int n_rows = 0;
    int n_dets = 0;
    int stall_request = 0;
    bit no_gaps = 1'b0;
    bit row_burst = 1'b0;

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function automatic void queue_det(input t_detection d);
        pending_dets = {pending_dets, d};
    endfunction

    function automatic void tab_add(input logic [drd_pkg::FEAT_W-1:0] feat,
                                    input logic last, input t_check_kind chk,
                                    input t_detection det);
        t_stim s;
        s.feat  = feat;
        s.last  = last;
        s.chk   = chk;
        s.det   = det;
        dir_tab = {dir_tab, s};
    endfunction

    // divide by 2^s, rounding toward zero
    function automatic longint shr_trunc(input longint v, input int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    // scaled corner and extent on one axis, clamped to the image
    function automatic bit fit_axis(input int c, input int s, input longint scale,
                                    input int dim, output longint p, output longint e);
        longint lim;
        lim = (dim > drd_pkg::IMG_MAX) ? longint'(drd_pkg::IMG_MAX) : longint'(dim);
        p = shr_trunc((2 * longint'(c) - longint'(s)) * scale, 33);
        e = shr_trunc(longint'(s) * scale, 32);
        if (lim == 0)
            return 1'b0;
        if (p > lim - 1)
            p = lim - 1;
        if (p < 0)
            p = 0;
        if (e > lim - p)
            e = lim - p;
        return e > 0;
    endfunction

    function automatic bit decode_feature(input logic [drd_pkg::FEAT_W-1:0] feat,
                                          input logic last, output t_detection det);
        int     v;
        longint left, top, bw, bh;
        bit     okx, oky, fired;
        v = int'(feat);
        det = '0;
        if (row_pos == 0)
            ctr_x = v;
        else if (row_pos == 1)
            ctr_y = v;
        else if (row_pos == 2)
            box_w = v;
        else if (row_pos == 3)
            box_h = v;
        else if (row_pos < drd_pkg::BOX_FIELDS + drd_pkg::MAX_CLASSES && v > top_score) begin
            top_score = v;
            top_class = row_pos - drd_pkg::BOX_FIELDS;
        end
        if (!last) begin
            if (row_pos < POS_LIMIT)
                row_pos++;
            return 1'b0;
        end
        okx = fit_axis(ctr_x, box_w, longint'(reg_shadow[drd_pkg::REG_X_SCALE]),
                       reg_shadow[drd_pkg::REG_IMAGE_WIDTH], left, bw);
        oky = fit_axis(ctr_y, box_h, longint'(reg_shadow[drd_pkg::REG_Y_SCALE]),
                       reg_shadow[drd_pkg::REG_IMAGE_HEIGHT], top, bh);
        fired = top_score > reg_shadow[drd_pkg::REG_SCORE_THRESHOLD] && okx && oky;
        if (fired) begin
            det.class_index = top_class[drd_pkg::CLASS_W-1:0];
            det.confidence  = (top_score > CONF_MAX) ? CONF_MAX[drd_pkg::CONF_W-1:0]
                                                     : top_score[drd_pkg::CONF_W-1:0];
            det.box_left    = left[drd_pkg::COORD_W-1:0];
            det.box_top     = top[drd_pkg::COORD_W-1:0];
            det.box_width   = bw[drd_pkg::EXT_W-1:0];
            det.box_height  = bh[drd_pkg::EXT_W-1:0];
        end
        row_pos = 0;
        ctr_x = 0;
        ctr_y = 0;
        box_w = 0;
        box_h = 0;
        top_score = 0;
        top_class = 0;
        return fired;
    endfunction

    task automatic read_reg(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field($sformatf("register %0d readback", idx), reg_shadow[idx], prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write then read back; the read's setup follows the write's access directly
    task automatic set_reg(input logic [2:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        reg_shadow[idx] = val;
        read_reg(idx);
    endtask

    task automatic send_feature(input logic [drd_pkg::FEAT_W-1:0] feat, input logic last,
                                input t_check_kind chk, input t_detection typed);
        t_detection det;
        bit         fired;
        int         gap;
        gap = (row_burst || no_gaps) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= feat;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        fired = decode_feature(feat, last, det);
        n_items++;
        if (chk == CHK_DET)
            queue_det(typed);
        else if (chk == CHK_MODEL && fired)
            queue_det(det);
        if (last)
            n_rows++;
    endtask

    // mostly well-formed rows with random content, some noise and short rows
    task automatic random_row();
        int          n_feat, style;
        logic [31:0] f;
        style = $urandom_range(0, 9);
        row_burst = ($urandom_range(0, 3) == 0);
        if (style < 8)
            n_feat = drd_pkg::BOX_FIELDS + (($urandom_range(0, 9) == 0) ? $urandom_range(9, 90)
                                                                         : $urandom_range(1, 8));
        else if (style == 8)
            n_feat = $urandom_range(1, 12);
        else
            n_feat = $urandom_range(1, drd_pkg::BOX_FIELDS);
        for (int i = 0; i < n_feat; i++) begin
            if (style == 8)
                f = $urandom;
            else if (i < 2)
                f = $urandom_range(0, 760 << 16) - (40 << 16);
            else if (i < drd_pkg::BOX_FIELDS)
                f = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 320 << 16);
            else
                f = $urandom_range(0, 90000) - 12000;
            send_feature(f, i == n_feat - 1, CHK_MODEL, '0);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_dets.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic setup_phase(input int p);
        int thr, xs, ys, w, h;
        thr = $urandom_range(0, 40000);
        xs  = $urandom_range(16384, 262144);
        ys  = $urandom_range(16384, 262144);
        w   = $urandom_range(1, 4096);
        h   = $urandom_range(1, 4096);
        case (p)
            1: begin
                thr = 0;
                xs  = 'hFFFFFF;
                ys  = 'hFFFFFF;
                w   = 4096;
                h   = 4096;
            end
            2: begin
                xs = 0;
                ys = 1;
                w  = 1;
                h  = 1;
            end
            3: begin
                w = 0;
                h = 8191;
            end
            4: begin
                w = 8191;
                h = 5000;
            end
            5: thr = 65535;
            6: begin
                w = 1;
                h = 1;
            end
            default: ;
        endcase
        set_reg(drd_pkg::REG_SCORE_THRESHOLD, thr);
        set_reg(drd_pkg::REG_X_SCALE, xs);
        set_reg(drd_pkg::REG_Y_SCALE, ys);
        set_reg(drd_pkg::REG_IMAGE_WIDTH, w);
        set_reg(drd_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // result sink: random stalls, calm stretches, and one long hold-off on request
    initial begin : result_sink
        int hold;
        bit calm;
        calm = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            hold = calm ? 0 : $urandom_range(0, 19);
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_detection got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            n_dets++;
            if (pending_dets.size() == 0) begin
                errors++;
                $error("detection transfer with none expected: %h", m_axis_tdata);
            end else begin
                want = pending_dets.pop_front();
                check_field("class_index", want.class_index, got.class_index);
                check_field("confidence", want.confidence, got.confidence);
                check_field("box_left", want.box_left, got.box_left);
                check_field("box_top", want.box_top, got.box_top);
                check_field("box_width", want.box_width, got.box_width);
                check_field("box_height", want.box_height, got.box_height);
                check_field("padding", want.pad, got.pad);
            end
        end
    end

    initial begin : watchdog
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int          goal;
        logic [31:0] f;
        int          phase_items [PHASES];

        phase_items = '{250, 80, 40, 40, 80, 70, 70, 70, 70};
        reg_shadow[drd_pkg::REG_SCORE_THRESHOLD] = drd_pkg::RST_THRESHOLD;
        reg_shadow[drd_pkg::REG_X_SCALE]         = drd_pkg::RST_SCALE;
        reg_shadow[drd_pkg::REG_Y_SCALE]         = drd_pkg::RST_SCALE;
        reg_shadow[drd_pkg::REG_IMAGE_WIDTH]     = drd_pkg::RST_WIDTH;
        reg_shadow[drd_pkg::REG_IMAGE_HEIGHT]    = drd_pkg::RST_HEIGHT;
        row_pos = 0;
        ctr_x = 0;
        ctr_y = 0;
        box_w = 0;
        box_h = 0;
        top_score = 0;
        top_class = 0;

        // plain box: 100,50 centre, 20x10, best of two scores
        tab_add(32'h0064_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0032_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0014_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h000A_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0000_8000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0000_C000, 1'b1, CHK_DET,
                t_detection'{pad: '0, box_height: 13'd10, box_width: 13'd20,
                             box_top: 12'd45, box_left: 12'd90,
                             confidence: 16'd49152, class_index: 10'd1});
        // one-feature row: box incomplete, no score
        tab_add(32'h7FFF_FFFF, 1'b1, CHK_NONE, '0);
        // extreme box values, saturated confidence
        tab_add(32'h8000_0000, 1'b0, CHK_MODEL, '0);
        tab_add(32'h7FFF_FFFF, 1'b0, CHK_MODEL, '0);
        tab_add(32'h7FFF_FFFF, 1'b0, CHK_MODEL, '0);
        tab_add(32'h7FFF_FFFF, 1'b0, CHK_MODEL, '0);
        tab_add(32'h7FFF_FFFF, 1'b1, CHK_MODEL, '0);
        // best score equal to the threshold, then negative and zero scores
        tab_add(32'h0064_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0032_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0014_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h000A_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0000_4000, 1'b0, CHK_NONE, '0);
        tab_add(32'hFFFF_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0000_0000, 1'b1, CHK_NONE, '0);
        // box larger than the image, tied scores keep the first class
        tab_add(32'h0140_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h00F0_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h03E8_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h03E8_0000, 1'b0, CHK_NONE, '0);
        tab_add(32'h0000_7530, 1'b0, CHK_NONE, '0);
        tab_add(32'h0000_7530, 1'b1, CHK_DET,
                t_detection'{pad: '0, box_height: 13'd480, box_width: 13'd640,
                             box_top: 12'd0, box_left: 12'd0,
                             confidence: 16'd30000, class_index: 10'd0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_reg(drd_pkg::REG_SCORE_THRESHOLD);
        read_reg(drd_pkg::REG_X_SCALE);
        read_reg(drd_pkg::REG_Y_SCALE);
        read_reg(drd_pkg::REG_IMAGE_WIDTH);
        read_reg(drd_pkg::REG_IMAGE_HEIGHT);
        @(posedge i_clk);

        for (int k = 0; k < dir_tab.size(); k++) begin
            row_burst = $urandom_range(0, 1);
            send_feature(dir_tab[k].feat, dir_tab[k].last, dir_tab[k].chk, dir_tab[k].det);
        end

        // back-to-back rows against a long sink hold-off so the pipeline fills
        no_gaps = 1'b1;
        stall_request = 400;
        repeat (STALL_ROWS) random_row();
        no_gaps = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                setup_phase(p);
                @(posedge i_clk);
            end
            goal = (p == 0) ? phase_items[0] : n_items + phase_items[p];
            while (n_items < goal)
                random_row();
            if (p == 0) begin
                // scores past the class limit must be ignored
                row_burst = 1'b1;
                for (int i = 0; i < LONG_ROW; i++) begin
                    if (i < 2)
                        f = 32'h0020_0000;
                    else if (i < drd_pkg::BOX_FIELDS)
                        f = 32'h0010_0000;
                    else if (i < drd_pkg::BOX_FIELDS + drd_pkg::MAX_CLASSES)
                        f = $urandom_range(0, 50000);
                    else
                        f = 32'h0001_2000;
                    send_feature(f, i == LONG_ROW - 1, CHK_MODEL, '0);
                end
            end
        end
        drain();

        $display("%0d rows (%0d features) over %0d register settings; %0d detections compared.",
                 n_rows, n_items, PHASES, n_dets);
        $display("Included a %0d-feature row, a long output stall, and zero and oversized images.",
                 LONG_ROW);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
